[src/touch_autocal_coordinate_map_defines.svh]
// assertion macros for the touch calibration mapper
`ifndef TOUCH_AUTOCAL_COORDINATE_MAP_DEFINES_SVH
`define TOUCH_AUTOCAL_COORDINATE_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define TACM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tacm assertion failed");
`define TACM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tacm assertion failed");
`else
`define TACM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TACM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/tacm_pkg.sv]
// shared types and constants of the touch calibration mapper
`default_nettype none

package tacm_pkg;

    localparam int RAW_W         = 16;
    localparam int COORD_W       = 12;
    localparam int PROD_W        = RAW_W + COORD_W;
    localparam int CNT_W         = $clog2(COORD_W);
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam logic [COORD_W-1:0] WIDTH_M1  = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] HEIGHT_M1 = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [COORD_W-1:0] COORD_NONE = '1;

    typedef enum logic [1:0] {
        ROT_SWAP_MIRROR_Y = 2'd0,
        ROT_MIRROR_BOTH   = 2'd1,
        ROT_SWAP_MIRROR_X = 2'd2,
        ROT_NONE          = 2'd3
    } rot_mode_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] mapped;
    } lane_status_t;

endpackage

`default_nettype wire

[src/tacm_lane.sv]
// one axis: min/max tracking, scale multiply and serial divide
`default_nettype none

module tacm_lane
    import tacm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [RAW_W-1:0]   raw,
    input  wire logic [COORD_W-1:0] size_m1,
    output lane_status_t            status
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_DONE = 4'b1000
    } lane_state_t;

    lane_state_t        state_reg, state_next;
    logic [RAW_W-1:0]   lo_reg, lo_next;
    logic [RAW_W-1:0]   hi_reg, hi_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [RAW_W-1:0]   span_reg, span_next;
    logic [RAW_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] bits_reg, bits_next;
    logic [COORD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               unset;
    logic [RAW_W-1:0]   seed_lo;
    logic [RAW_W-1:0]   seed_hi;
    logic [RAW_W-1:0]   span;
    logic [RAW_W-1:0]   offset;
    logic [PROD_W-1:0]  prod;
    logic [RAW_W:0]     trial;
    logic [RAW_W:0]     trial_sub;
    logic               trial_ge;

    assign unset     = (lo_reg == '0) && (hi_reg == '0);
    assign seed_lo   = unset ? raw : lo_reg;
    assign seed_hi   = unset ? raw : hi_reg;
    assign span      = hi_reg - lo_reg;
    assign offset    = raw_reg - lo_reg;
    assign prod      = PROD_W'(offset) * PROD_W'(size_m1);
    assign trial     = {rem_reg, bits_reg[COORD_W-1]};
    assign trial_ge  = trial >= {1'b0, span_reg};
    assign trial_sub = trial - {1'b0, span_reg};

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        raw_next   = raw_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (start)
                begin
                    // widen the window, seeding an unset axis
                    lo_next    = (raw < seed_lo) ? raw : seed_lo;
                    hi_next    = (raw > seed_hi) ? raw : seed_hi;
                    raw_next   = raw;
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                span_next = span;
                rem_next  = prod[PROD_W-1:COORD_W];
                bits_next = prod[COORD_W-1:0];
                cnt_next  = CNT_W'(COORD_W - 1);
                quo_next  = '0;
                // flat axis maps to zero
                state_next = (span == '0) ? L_DONE : L_DIV;
            end
            L_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
                quo_next  = {quo_reg[COORD_W-2:0], trial_ge};
                bits_next = {bits_reg[COORD_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = L_DONE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

    assign status.done   = (state_reg == L_DONE);
    assign status.mapped = quo_reg;

endmodule

`default_nettype wire

[src/tacm_merge.sv]
// rotation of the two lane results and the output register
`default_nettype none

module tacm_merge
    import tacm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic               touched,
    input  wire logic [COORD_W-1:0] map_x,
    input  wire logic [COORD_W-1:0] map_y,
    input  wire rot_mode_t          rot,
    input  wire logic               m_axis_tready,
    output logic                    m_axis_tvalid,
    output logic [2*COORD_W-1:0]    m_axis_tdata,  // screen_x, screen_y
    output logic                    m_axis_tuser   // touched
);

    logic                 tvalid_reg, tvalid_next;
    logic [2*COORD_W-1:0] tdata_reg;
    logic                 tuser_reg;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;

    always_comb
    begin
        unique case (rot)
            ROT_SWAP_MIRROR_Y:
            begin
                sx = map_y;
                sy = WIDTH_M1 - map_x;
            end
            ROT_MIRROR_BOTH:
            begin
                sx = WIDTH_M1 - map_x;
                sy = HEIGHT_M1 - map_y;
            end
            ROT_SWAP_MIRROR_X:
            begin
                sx = HEIGHT_M1 - map_y;
                sy = map_x;
            end
            default:
            begin
                sx = map_x;
                sy = map_y;
            end
        endcase
    end

    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (load)
        begin
            tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tuser_reg <= touched;
            tdata_reg <= touched ? {sy, sx} : {COORD_NONE, COORD_NONE};
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

`default_nettype wire

[src/touch_autocal_coordinate_map.sv]
// top level of the self-calibrating touch coordinate mapper
//
// input stream: s_axis_tdata carries raw_x (bits 15:0) and raw_y (31:16),
// s_axis_tuser carries pen_down. output stream: m_axis_tdata carries
// screen_x (11:0) and screen_y (23:12), m_axis_tuser carries touched.
// cfg_wr_en / cfg_wr_data write the 2-bit rotation mode; write only while idle.
// one transaction is processed at a time. a pen-down sample runs through both
// axis lanes in parallel: the min/max window widens at acceptance, then a
// multiply step, a 12-step restoring divide (skipped on a flat axis), a step to
// see both lanes done and a load step that raises m_axis_tvalid. a pen-up
// sample skips the lanes and goes straight to the load step. s_axis_tready
// returns the cycle after the load, so a new sample is taken only after the
// last one is loaded. the result sits in an output register; while the
// receiver stalls, the finished transaction waits in the load step and
// s_axis_tready stays low.
// reset clears the calibration window, rotation mode 0 and output valid.
`default_nettype none

`include "touch_autocal_coordinate_map_defines.svh"

module touch_autocal_coordinate_map
    import tacm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [2*RAW_W-1:0]   s_axis_tdata,  // raw_x, raw_y
    input  wire logic                 s_axis_tuser,  // pen_down
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [2*COORD_W-1:0]      m_axis_tdata,  // screen_x, screen_y
    output logic                      m_axis_tuser,  // touched
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_EMIT = 3'b100
    } top_state_t;

    top_state_t   state_reg, state_next;
    rot_mode_t    rot_reg;
    logic         pen_reg;
    logic         accept;
    logic         start;
    logic         out_free;
    logic         load;
    lane_status_t lane_x;
    lane_status_t lane_y;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && s_axis_tuser;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign load          = (state_reg == S_EMIT) && out_free;

    tacm_lane u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .raw     (s_axis_tdata[RAW_W-1:0]),
        .size_m1 (WIDTH_M1),
        .status  (lane_x)
    );

    tacm_lane u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .raw     (s_axis_tdata[2*RAW_W-1:RAW_W]),
        .size_m1 (HEIGHT_M1),
        .status  (lane_y)
    );

    tacm_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .touched       (pen_reg),
        .map_x         (lane_x.mapped),
        .map_y         (lane_y.mapped),
        .rot           (rot_reg),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_axis_tuser ? S_BUSY : S_EMIT;
                end
            end
            S_BUSY:
            begin
                if (lane_x.done && lane_y.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rot_reg   <= ROT_SWAP_MIRROR_Y;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                rot_reg <= rot_mode_t'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pen_reg <= s_axis_tuser;
        end
    end

    `TACM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !s_axis_tready)
    `TACM_ASSERT_IMP(a_pen_up_all_ones, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata == {COORD_NONE, COORD_NONE})
    `TACM_ASSERT_IMP(a_x_in_range, clk, rst_n, lane_x.done, lane_x.mapped <= WIDTH_M1)
    `TACM_ASSERT_IMP(a_y_in_range, clk, rst_n, lane_y.done, lane_y.mapped <= HEIGHT_M1)
    `TACM_ASSERT_NEXT(a_emit_holds, clk, rst_n,
        (state_reg == S_EMIT) && m_axis_tvalid && !m_axis_tready, state_reg == S_EMIT)

endmodule

`default_nettype wire

[tb/sv/touch_autocal_coordinate_map_checker.sv]
// checker that predicts and compares the touch coordinate mapper results
`default_nettype none

module touch_autocal_coordinate_map_checker
    import tacm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [2*RAW_W-1:0]   s_axis_tdata,  // raw_x, raw_y
    input  wire logic                 s_axis_tuser,  // pen_down
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [2*COORD_W-1:0] m_axis_tdata,  // screen_x, screen_y
    input  wire logic                 m_axis_tuser,  // touched
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_wr_data,
    output int                        mismatch_count,
    output int                        pending
);

    typedef struct packed {
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
    } span_t;

    typedef struct packed {
        logic               touched;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coord_t;

    span_t     span_x;
    span_t     span_y;
    rot_mode_t rotation;
    coord_t    coord_q[$];

    // an all-zero window is unset and takes the first reading
    function automatic span_t stretch(span_t s, logic [RAW_W-1:0] raw);
        span_t w;
        w = s;
        if (w.lo == '0 && w.hi == '0)
        begin
            w.lo = raw;
            w.hi = raw;
        end
        if (raw < w.lo)
            w.lo = raw;
        if (raw > w.hi)
            w.hi = raw;
        return w;
    endfunction

    // flat window maps to zero
    function automatic logic [COORD_W-1:0] scale(logic [RAW_W-1:0] raw, span_t s,
                                                 int unsigned size);
        int unsigned r;
        r = raw;
        if (s.hi <= s.lo)
            return '0;
        if (r < s.lo)
            r = s.lo;
        if (r > s.hi)
            r = s.hi;
        return COORD_W'(((r - s.lo) * (size - 1)) / (s.hi - s.lo));
    endfunction

    function automatic coord_t orient(logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my,
                                      rot_mode_t rot);
        coord_t c;
        c.touched = 1'b1;
        case (rot)
            ROT_SWAP_MIRROR_Y:
            begin
                c.x = my;
                c.y = WIDTH_M1 - mx;
            end
            ROT_MIRROR_BOTH:
            begin
                c.x = WIDTH_M1 - mx;
                c.y = HEIGHT_M1 - my;
            end
            ROT_SWAP_MIRROR_X:
            begin
                c.x = HEIGHT_M1 - my;
                c.y = mx;
            end
            default:
            begin
                c.x = mx;
                c.y = my;
            end
        endcase
        return c;
    endfunction

    always @(posedge clk)
    begin : watch
        coord_t           got;
        coord_t           want;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        if (!rst_n)
        begin
            span_x         = '0;
            span_y         = '0;
            rotation       = ROT_SWAP_MIRROR_Y;
            mismatch_count = 0;
            coord_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.touched = m_axis_tuser;
                got.x       = m_axis_tdata[COORD_W-1:0];
                got.y       = m_axis_tdata[2*COORD_W-1:COORD_W];
                if (coord_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction: touched=%0d x=%0d y=%0d",
                                 got.touched, got.x, got.y);
                end
                else
                begin
                    want = coord_q.pop_front();
                    if (got.touched !== want.touched || got.x !== want.x ||
                        got.y !== want.y)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: touched %0d/%0d x %0d/%0d y %0d/%0d (exp/act)",
                                     want.touched, got.touched, want.x, got.x,
                                     want.y, got.y);
                    end
                end
            end
            if (cfg_wr_en)
                rotation = rot_mode_t'(cfg_wr_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                rx = s_axis_tdata[RAW_W-1:0];
                ry = s_axis_tdata[2*RAW_W-1:RAW_W];
                if (!s_axis_tuser)
                begin
                    want.touched = 1'b0;
                    want.x       = COORD_NONE;
                    want.y       = COORD_NONE;
                    coord_q.push_back(want);
                end
                else
                begin
                    span_x = stretch(span_x, rx);
                    span_y = stretch(span_y, ry);
                    coord_q.push_back(orient(scale(rx, span_x, SCREEN_WIDTH),
                                             scale(ry, span_y, SCREEN_HEIGHT), rotation));
                end
            end
        end
        pending = coord_q.size();
    end

endmodule

`default_nettype wire

[tb/sv/touch_autocal_coordinate_map_tb.sv]
// testbench top: stimulus, flow control and verdict for the touch coordinate mapper
`default_nettype none

module touch_autocal_coordinate_map_tb;
    import tacm_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 120;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [2*RAW_W-1:0]   s_axis_tdata;   // raw_x, raw_y
    logic                 s_axis_tuser;   // pen_down
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [2*COORD_W-1:0] m_axis_tdata;   // screen_x, screen_y
    logic                 m_axis_tuser;   // touched
    logic                 cfg_wr_en;
    logic [1:0]           cfg_wr_data;
    int                   mismatch_count;
    int                   pending;
    logic                 no_idle;
    logic                 hold_req;
    logic                 hold_done;

    touch_autocal_coordinate_map u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    touch_autocal_coordinate_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic offer_sample(input logic pen, input logic [RAW_W-1:0] rx,
                                input logic [RAW_W-1:0] ry);
        while (!no_idle && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pen;
        s_axis_tdata  <= {ry, rx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_rotation(input rot_mode_t rot);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rot;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // reading spread around a center, clipped to the raw range
    function automatic logic [RAW_W-1:0] near(int center, int hw);
        int v;
        v = center - hw + int'($urandom_range(2 * hw));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return RAW_W'(v);
    endfunction

    // receiver flow control
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_axis_tready <= no_idle || $urandom_range(99) >= 34;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int hw;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset orientation, pen up, zero reading leaves axes unset
        offer_sample(1'b0, 16'hFFFF, 16'hFFFF);
        offer_sample(1'b1, 16'h0000, 16'h0000);
        offer_sample(1'b0, 16'h0000, 16'h0000);
        wait_drained();
        set_rotation(ROT_NONE);
        // seeding, flat axes, widening both ways
        offer_sample(1'b1, 16'h8000, 16'h0000);
        offer_sample(1'b1, 16'h8000, 16'h4000);
        offer_sample(1'b1, 16'h7000, 16'h4000);
        offer_sample(1'b1, 16'h9000, 16'h5000);
        offer_sample(1'b1, 16'h8000, 16'h4800);
        offer_sample(1'b1, 16'h6000, 16'h3000);
        offer_sample(1'b1, 16'h7800, 16'h4400);
        offer_sample(1'b0, 16'h1234, 16'hABCD);
        offer_sample(1'b1, 16'h9000, 16'h5000);
        offer_sample(1'b1, 16'h6000, 16'h3000);

        n = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            set_rotation(rot_mode_t'(p % 4));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                no_idle = (n >= 400 && n < 520);
                if (n == 700)
                    hold_req = 1'b1;
                // the window grows slowly so widening keeps happening
                hw = 16'h1000 + n * 40;
                if ($urandom_range(99) < 8)
                    offer_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom));
                else
                    offer_sample(1'b1, near(16'h7800, hw), near(16'h4000, hw));
                n++;
            end
        end
        no_idle = 1'b0;

        offer_sample(1'b1, 16'h0000, 16'h0000);
        offer_sample(1'b1, 16'hFFFF, 16'hFFFF);
        offer_sample(1'b1, 16'h0000, 16'hFFFF);
        offer_sample(1'b1, 16'hFFFF, 16'h0000);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/tacm_pkg.sv
src/tacm_lane.sv
src/tacm_merge.sv
src/touch_autocal_coordinate_map.sv
tb/sv/touch_autocal_coordinate_map_checker.sv
tb/sv/touch_autocal_coordinate_map_tb.sv
